[rtl/glpf_pkg.sv]
// ----------------------------------------------------------------------------
// glpf_pkg
// shared constants, types and helpers of the grid local peak finder
// ----------------------------------------------------------------------------
package glpf_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int MAX_ROWS  = 128;
    localparam int MAX_COLS  = 128;
    localparam int IDX_W     = 7;
    localparam int SIZE_W    = 8;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 1;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 16;
    localparam int ENTRY_W   = 2 * SAMPLE_W;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'd1;

    // peak slots raised by one sample
    localparam int SLOT_ABOVE = 0;  // cell above the sample
    localparam int SLOT_LEFT  = 1;  // last-row cell left of the sample
    localparam int SLOT_SELF  = 2;  // the sample itself, last cell of frame
    localparam int SLOTS      = 3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] older;
        logic [SAMPLE_W-1:0] middle;
    } line_entry_t;

    typedef struct packed {
        logic [SLOTS-1:0] hit;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } peak_set_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] r;
        begin
            if (v < SIZE_W'(2))
                r = SIZE_W'(2);
            else if (v > hi)
                r = hi;
            else
                r = v;
            return r;
        end
    endfunction

endpackage

[rtl/glpf_ram.sv]
// ----------------------------------------------------------------------------
// glpf_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module glpf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/glpf_peak_queue.sv]
// ----------------------------------------------------------------------------
// glpf_peak_queue
// holds the peaks raised by one sample and sends them out one per transfer
// ----------------------------------------------------------------------------
module glpf_peak_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  glpf_pkg::peak_set_t        load_set,
    output logic                       can_load,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [glpf_pkg::IDX_W-1:0] peak_row,
    output logic [glpf_pkg::IDX_W-1:0] peak_col,
    output logic                       last_of_run
);

    logic [glpf_pkg::SLOTS-1:0] hit_reg;
    logic [glpf_pkg::SLOTS-1:0] hit_next;
    logic [glpf_pkg::IDX_W-1:0] row_reg;
    logic [glpf_pkg::IDX_W-1:0] col_reg;
    logic                       valid_reg;
    logic [glpf_pkg::IDX_W-1:0] prow_reg;
    logic [glpf_pkg::IDX_W-1:0] pcol_reg;
    logic                       last_reg;

    logic                       move;
    logic [glpf_pkg::SLOTS-1:0] pick;
    logic [glpf_pkg::SLOTS-1:0] remaining;
    logic [glpf_pkg::IDX_W-1:0] sel_row;
    logic [glpf_pkg::IDX_W-1:0] sel_col;

    always_comb
    begin
        pick    = '0;
        sel_row = row_reg;
        sel_col = col_reg;
        if (hit_reg[glpf_pkg::SLOT_ABOVE])
        begin
            pick[glpf_pkg::SLOT_ABOVE] = 1'b1;
            sel_row = row_reg - glpf_pkg::IDX_W'(1);
        end
        else if (hit_reg[glpf_pkg::SLOT_LEFT])
        begin
            pick[glpf_pkg::SLOT_LEFT] = 1'b1;
            sel_col = col_reg - glpf_pkg::IDX_W'(1);
        end
        else if (hit_reg[glpf_pkg::SLOT_SELF])
        begin
            pick[glpf_pkg::SLOT_SELF] = 1'b1;
        end
    end

    assign remaining = hit_reg & ~pick;
    assign move      = (|hit_reg) && (!valid_reg || out_ready);
    assign can_load  = (hit_reg == '0) || (move && (remaining == '0));

    always_comb
    begin
        if (load)
            hit_next = load_set.hit;
        else if (move)
            hit_next = remaining;
        else
            hit_next = hit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
            if (move)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg <= load_set.row;
            col_reg <= load_set.col;
        end
        if (move)
        begin
            prow_reg <= sel_row;
            pcol_reg <= sel_col;
            last_reg <= (remaining == '0);
        end
    end

    assign out_valid   = valid_reg;
    assign peak_row    = prow_reg;
    assign peak_col    = pcol_reg;
    assign last_of_run = last_reg;

endmodule

[rtl/grid_local_peak_finder.sv]
// ----------------------------------------------------------------------------
// grid_local_peak_finder
// 4-neighbour local maximum over a raster frame, two lines kept in one ram
// ----------------------------------------------------------------------------
// a sample's peaks are stored in the peak queue at its transfer, then registered onto the output
// throughput: one sample per cycle while each sample raises at most one peak and
// the output is ready; a sample with more peaks holds the input until its last is sent
// the line ram is prefetched two columns ahead, so no read stalls the input
// reset: frame size 2x2, position row 0 column 0, no pending peaks
// ----------------------------------------------------------------------------
module grid_local_peak_finder (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [glpf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [glpf_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [glpf_pkg::TDATA_IN_W-1:0]      s_tdata,   // sample_value
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [glpf_pkg::TDATA_OUT_W-1:0]     m_tdata,   // peak_row, peak_col, zero pad
    output logic                                 m_tlast
);

    localparam int AW = $clog2(glpf_pkg::MAX_COLS);
    localparam int SW = glpf_pkg::SAMPLE_W;
    localparam int IW = glpf_pkg::IDX_W;
    localparam int ZW = glpf_pkg::SIZE_W;

    logic [glpf_pkg::CFG_W-1:0] frame_rows_reg;
    logic [glpf_pkg::CFG_W-1:0] frame_cols_reg;
    logic [ZW-1:0]              rows_eff;
    logic [ZW-1:0]              cols_eff;

    logic [IW-1:0]              row_reg;
    logic [IW-1:0]              col_reg;
    logic signed [SW-1:0]       prev_reg;
    logic signed [SW-1:0]       pprev_reg;
    logic signed [SW-1:0]       left_reg;
    glpf_pkg::line_entry_t      cur_reg;
    glpf_pkg::line_entry_t      nxt_reg;
    logic                       pend_reg;
    logic                       fwd_reg;
    glpf_pkg::line_entry_t      fwd_data_reg;

    glpf_pkg::line_entry_t      ram_rdata;
    glpf_pkg::line_entry_t      nxt_eff;
    glpf_pkg::line_entry_t      wr_entry;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              rd_addr;
    logic [ZW-1:0]              col_plus2;

    logic                       accept;
    logic                       can_load;
    glpf_pkg::peak_set_t        peak_set;

    logic signed [SW-1:0]       x;
    logic signed [SW-1:0]       up_v;
    logic signed [SW-1:0]       mid_v;
    logic signed [SW-1:0]       right_v;
    logic                       row_end;
    logic                       frame_last_row;
    logic                       hit_above;
    logic                       hit_left;
    logic                       hit_self;

    logic [IW-1:0]              peak_row;
    logic [IW-1:0]              peak_col;
    logic                       last_of_run;

    assign rows_eff = glpf_pkg::clamp_size(frame_rows_reg, ZW'(glpf_pkg::MAX_ROWS));
    assign cols_eff = glpf_pkg::clamp_size(frame_cols_reg, ZW'(glpf_pkg::MAX_COLS));

    assign s_tready = can_load;
    assign accept   = s_tvalid && s_tready;

    assign x       = $signed(s_tdata[SW-1:0]);
    assign up_v    = $signed(cur_reg.older);
    assign mid_v   = $signed(cur_reg.middle);
    assign nxt_eff = pend_reg ? (fwd_reg ? fwd_data_reg : ram_rdata) : nxt_reg;
    assign right_v = $signed(nxt_eff.middle);

    assign row_end        = ({1'b0, col_reg} + ZW'(1)) == cols_eff;
    assign frame_last_row = ({1'b0, row_reg} + ZW'(1)) == rows_eff;

    // line ram: write the current column, prefetch two columns ahead
    assign wr_entry.older  = cur_reg.middle;
    assign wr_entry.middle = s_tdata[SW-1:0];
    assign wr_addr         = col_reg[AW-1:0];
    assign col_plus2       = {1'b0, col_reg} + ZW'(2);

    always_comb
    begin
        if (col_plus2 >= cols_eff)
            rd_addr = AW'(col_plus2 - cols_eff);
        else
            rd_addr = col_plus2[AW-1:0];
    end

    glpf_ram #(
        .WIDTH (glpf_pkg::ENTRY_W),
        .DEPTH (glpf_pkg::MAX_COLS)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    // neighbour compares
    always_comb
    begin
        hit_above = (row_reg != '0) && (mid_v >= x);
        if (row_reg >= IW'(2))
            hit_above = hit_above && (mid_v >= up_v);
        if (col_reg != '0)
            hit_above = hit_above && (mid_v >= left_reg);
        if (!row_end)
            hit_above = hit_above && (mid_v >= right_v);

        hit_left = frame_last_row && (col_reg != '0) && (prev_reg >= x) && (prev_reg >= left_reg);
        if (col_reg >= IW'(2))
            hit_left = hit_left && (prev_reg >= pprev_reg);

        hit_self = frame_last_row && row_end && (x >= mid_v) && (x >= prev_reg);
    end

    always_comb
    begin
        peak_set.hit = '0;
        peak_set.hit[glpf_pkg::SLOT_ABOVE] = hit_above;
        peak_set.hit[glpf_pkg::SLOT_LEFT]  = hit_left;
        peak_set.hit[glpf_pkg::SLOT_SELF]  = hit_self;
        peak_set.row = row_reg;
        peak_set.col = col_reg;
    end

    // config and frame position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_rows_reg <= glpf_pkg::CFG_W'(2);
            frame_cols_reg <= glpf_pkg::CFG_W'(2);
            row_reg        <= '0;
            col_reg        <= '0;
            prev_reg       <= '0;
            pprev_reg      <= '0;
            pend_reg       <= 1'b0;
            fwd_reg        <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                glpf_pkg::REG_FRAME_ROWS: frame_rows_reg <= cfg_data;
                glpf_pkg::REG_FRAME_COLS: frame_cols_reg <= cfg_data;
                default: ;
            endcase
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            pprev_reg <= prev_reg;
            prev_reg  <= x;
            pend_reg  <= 1'b1;
            fwd_reg   <= (rd_addr == wr_addr);
            if (row_end)
            begin
                col_reg <= '0;
                row_reg <= frame_last_row ? '0 : row_reg + IW'(1);
            end
            else
            begin
                col_reg <= col_reg + IW'(1);
            end
        end
        else
        begin
            pend_reg <= 1'b0;
            fwd_reg  <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg      <= nxt_eff;
            left_reg     <= mid_v;
            fwd_data_reg <= wr_entry;
        end
        else if (pend_reg)
        begin
            nxt_reg <= nxt_eff;
        end
    end

    glpf_peak_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .load_set    (peak_set),
        .can_load    (can_load),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .peak_row    (peak_row),
        .peak_col    (peak_col),
        .last_of_run (last_of_run)
    );

    assign m_tdata = {(glpf_pkg::TDATA_OUT_W - 2 * IW)'(0), peak_col, peak_row};
    assign m_tlast = last_of_run;

endmodule

[rtl/glpf_checker.sv]
// ----------------------------------------------------------------------------
// glpf_checker
// port-level checks of the grid local peak finder, bound to the top level
// ----------------------------------------------------------------------------
module glpf_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [glpf_pkg::TDATA_OUT_W-1:0] m_tdata,
    input logic                             m_tlast
);

    // stalled output transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // a run not yet ended continues in the next cycle
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("peak run broken before tlast");

    // a new result only follows an earlier input transfer
    a_out_from_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a matching input transfer");

    // pad bits above the peak coordinates stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[glpf_pkg::TDATA_OUT_W-1:2*glpf_pkg::IDX_W] == '0)
        else $error("nonzero pad bits in output");

endmodule

bind grid_local_peak_finder glpf_checker u_glpf_checker (.*);

[test/testbench.sv]
// ----------------------------------------------------------------------------
// grid local peak finder testbench
// streams raster frames of signed samples through the peak finder and
// compares every reported peak, in order, with a cycle-free prediction of
// the 4-neighbour local maximum kept in a small scoreboard class; frame
// sizes are changed between phases, with random stalls on both sides
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 260;
    localparam int FEED_CAP     = 60;
    localparam int WIDE_COLS    = 64;
    localparam int HOLD_CYCLES  = 150;
    localparam int SETTLE       = 8;
    localparam int QUIET_LIMIT  = 2000;

    typedef struct packed {
        logic [glpf_pkg::IDX_W-1:0] row;
        logic [glpf_pkg::IDX_W-1:0] col;
        logic                       last;
    } peak_t;

    class peak_ledger;
        logic signed [glpf_pkg::SAMPLE_W-1:0] older_row [glpf_pkg::MAX_COLS];
        logic signed [glpf_pkg::SAMPLE_W-1:0] middle_row [glpf_pkg::MAX_COLS];
        logic signed [glpf_pkg::SAMPLE_W-1:0] left_one;
        logic signed [glpf_pkg::SAMPLE_W-1:0] left_two;
        int unsigned                          row_pos;
        int unsigned                          col_pos;
        logic [glpf_pkg::CFG_W-1:0]           rows_reg;
        logic [glpf_pkg::CFG_W-1:0]           cols_reg;
        peak_t                                due_peaks [$];
        int unsigned                          mismatches;

        function new();
            foreach (older_row[i])
            begin
                older_row[i]  = '0;
                middle_row[i] = '0;
            end
            left_one   = '0;
            left_two   = '0;
            row_pos    = 0;
            col_pos    = 0;
            rows_reg   = glpf_pkg::CFG_W'(2);
            cols_reg   = glpf_pkg::CFG_W'(2);
            mismatches = 0;
        endfunction

        function int unsigned frame_size(logic [glpf_pkg::CFG_W-1:0] v, int unsigned hi);
            if (v < 2)
                return 2;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function void apply_config(logic [glpf_pkg::CFG_IDX_W-1:0] idx,
                                   logic [glpf_pkg::CFG_W-1:0] value);
            if (idx == glpf_pkg::REG_FRAME_ROWS)
                rows_reg = value;
            else
                cols_reg = value;
            row_pos = 0;
            col_pos = 0;
        endfunction

        // predicts the peaks decided by one accepted sample
        function void take_sample(logic [glpf_pkg::SAMPLE_W-1:0] raw);
            int unsigned                          n_rows;
            int unsigned                          n_cols;
            int unsigned                          r;
            int unsigned                          c;
            logic signed [glpf_pkg::SAMPLE_W-1:0] x;
            logic signed [glpf_pkg::SAMPLE_W-1:0] up_old;
            logic signed [glpf_pkg::SAMPLE_W-1:0] mid_c;
            peak_t                                found [$];
            bit                                   ok;
            n_rows = frame_size(rows_reg, glpf_pkg::MAX_ROWS);
            n_cols = frame_size(cols_reg, glpf_pkg::MAX_COLS);
            x = raw;
            if (row_pos >= n_rows || col_pos >= n_cols)
            begin
                row_pos = 0;
                col_pos = 0;
            end
            r = row_pos;
            c = col_pos;
            up_old = older_row[c];
            mid_c  = middle_row[c];
            older_row[c]  = mid_c;
            middle_row[c] = x;

            // cell above, now that its lower neighbour is here
            if (r >= 1)
            begin
                ok = (mid_c >= x);
                if (r >= 2)
                    ok = ok && (mid_c >= up_old);
                if (c > 0)
                    ok = ok && (mid_c >= older_row[c - 1]);
                if (c + 1 < n_cols)
                    ok = ok && (mid_c >= middle_row[c + 1]);
                if (ok)
                    found.push_back('{row: glpf_pkg::IDX_W'(r - 1),
                                      col: glpf_pkg::IDX_W'(c), last: 1'b0});
            end

            if (r == n_rows - 1)
            begin
                // last-row cell to the left
                if (c >= 1)
                begin
                    ok = (left_one >= x) && (left_one >= older_row[c - 1]);
                    if (c >= 2)
                        ok = ok && (left_one >= left_two);
                    if (ok)
                        found.push_back('{row: glpf_pkg::IDX_W'(r),
                                          col: glpf_pkg::IDX_W'(c - 1), last: 1'b0});
                end
                // final cell of the frame
                if (c == n_cols - 1)
                begin
                    ok = (x >= older_row[c]) && (x >= left_one);
                    if (ok)
                        found.push_back('{row: glpf_pkg::IDX_W'(r),
                                          col: glpf_pkg::IDX_W'(c), last: 1'b0});
                end
            end

            left_two = left_one;
            left_one = x;
            if (c + 1 < n_cols)
                col_pos = c + 1;
            else
            begin
                col_pos = 0;
                row_pos = (r + 1 < n_rows) ? r + 1 : 0;
            end

            if (found.size() > 0)
                found[found.size() - 1].last = 1'b1;
            foreach (found[i])
                due_peaks.push_back(found[i]);
        endfunction

        function void match_peak(logic [glpf_pkg::TDATA_OUT_W-1:0] data, logic last);
            peak_t                      want;
            logic [glpf_pkg::IDX_W-1:0] got_row;
            logic [glpf_pkg::IDX_W-1:0] got_col;
            got_row = data[glpf_pkg::IDX_W-1:0];
            got_col = data[2*glpf_pkg::IDX_W-1:glpf_pkg::IDX_W];
            if (due_peaks.size() == 0)
            begin
                $error("unexpected peak row %0d col %0d last %0b", got_row, got_col, last);
                mismatches++;
                return;
            end
            want = due_peaks.pop_front();
            if (got_row !== want.row)
            begin
                $error("peak_row expected %0d actual %0d", want.row, got_row);
                mismatches++;
            end
            if (got_col !== want.col)
            begin
                $error("peak_col expected %0d actual %0d", want.col, got_col);
                mismatches++;
            end
            if (last !== want.last)
            begin
                $error("last_of_run expected %0b actual %0b", want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_write = 1'b0;
    logic [glpf_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [glpf_pkg::CFG_W-1:0]       cfg_data = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [glpf_pkg::TDATA_IN_W-1:0]  s_tdata = '0;   // sample_value
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [glpf_pkg::TDATA_OUT_W-1:0] m_tdata;        // peak_row, peak_col, zero pad
    logic                             m_tlast;        // last_of_run

    peak_ledger sb = new();
    bit         no_idle = 1'b0;
    bit         hold_off_request = 1'b0;
    int         hold_left = 0;
    int         quiet_cycles = 0;

    grid_local_peak_finder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [glpf_pkg::SAMPLE_W-1:0] pick_sample();
        logic [glpf_pkg::SAMPLE_W-1:0] near_zero;
        near_zero = glpf_pkg::SAMPLE_W'($urandom_range(4));
        case ($urandom_range(9))
            0, 1, 2, 3: return near_zero - glpf_pkg::SAMPLE_W'(2);
            4, 5, 6:    return glpf_pkg::SAMPLE_W'($urandom());
            7:
            begin
                case ($urandom_range(3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            default:    return 16'h0064;
        endcase
    endfunction

    function automatic logic [glpf_pkg::CFG_W-1:0] pick_size();
        case ($urandom_range(19))
            0:       return glpf_pkg::CFG_W'(0);
            1:       return glpf_pkg::CFG_W'(1);
            2:       return glpf_pkg::CFG_W'(255);
            3:       return glpf_pkg::CFG_W'($urandom_range(7, 12));
            default: return glpf_pkg::CFG_W'($urandom_range(2, 6));
        endcase
    endfunction

    task automatic send_sample(input logic [glpf_pkg::SAMPLE_W-1:0] value);
        if (!no_idle)
            while ($urandom_range(99) < 38)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        sb.take_sample(value);
    endtask

    task automatic feed(input int n);
        repeat (n)
            send_sample(pick_sample());
    endtask

    // sender stops until every predicted peak has come out
    task automatic pause_for_idle();
        s_tvalid <= 1'b0;
        while (sb.due_peaks.size() != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [glpf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [glpf_pkg::CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.apply_config(idx, value);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // receiver with random stalls and one long hold-off
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.match_peak(m_tdata, m_tlast);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= no_idle || ($urandom_range(99) >= 38);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_write)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned random_taken;
        int unsigned n;
        int unsigned n_rows;
        int unsigned n_cols;
        bit          tall_done;
        bit          wide_done;
        random_taken = 0;
        tall_done = 1'b0;
        wide_done = 1'b0;

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset size 2x2, flat plateau: every cell ties and is a peak
        repeat (4)
            send_sample(16'h0005);
        pause_for_idle();

        // 3x3 with the sample extremes
        write_reg(glpf_pkg::REG_FRAME_ROWS, glpf_pkg::CFG_W'(3));
        write_reg(glpf_pkg::REG_FRAME_COLS, glpf_pkg::CFG_W'(3));
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h7FFF);
        send_sample(16'h7FFF);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h7FFF);
        pause_for_idle();

        // sizes below the minimum clamp to 2
        write_reg(glpf_pkg::REG_FRAME_ROWS, glpf_pkg::CFG_W'(0));
        write_reg(glpf_pkg::REG_FRAME_COLS, glpf_pkg::CFG_W'(1));
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        pause_for_idle();

        // oversize clamps to the maximum; a write mid-frame restarts the frame
        write_reg(glpf_pkg::REG_FRAME_ROWS, glpf_pkg::CFG_W'(255));
        write_reg(glpf_pkg::REG_FRAME_COLS, glpf_pkg::CFG_W'(2));
        send_sample(16'h0001);
        send_sample(16'h0002);
        send_sample(16'h0003);
        pause_for_idle();
        write_reg(glpf_pkg::REG_FRAME_COLS, glpf_pkg::CFG_W'(255));
        send_sample(16'h0004);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        pause_for_idle();

        while (random_taken < RANDOM_ITEMS)
        begin
            if (!tall_done && random_taken >= 40)
            begin
                write_reg(glpf_pkg::REG_FRAME_ROWS, glpf_pkg::CFG_W'(128));
                write_reg(glpf_pkg::REG_FRAME_COLS, glpf_pkg::CFG_W'($urandom_range(2, 3)));
                feed(30);
                random_taken += 30;
                tall_done = 1'b1;
            end
            else if (!wide_done && random_taken >= 90)
            begin
                // whole wide frame at full rate, receiver held off at its start
                write_reg(glpf_pkg::REG_FRAME_ROWS, glpf_pkg::CFG_W'(2));
                write_reg(glpf_pkg::REG_FRAME_COLS, glpf_pkg::CFG_W'(WIDE_COLS));
                no_idle = 1'b1;
                hold_off_request = 1'b1;
                feed(2 * WIDE_COLS);
                random_taken += 2 * WIDE_COLS;
                no_idle = 1'b0;
                wide_done = 1'b1;
            end
            else
            begin
                if ($urandom_range(3) != 0)
                    write_reg(glpf_pkg::REG_FRAME_ROWS, pick_size());
                if ($urandom_range(3) != 0)
                    write_reg(glpf_pkg::REG_FRAME_COLS, pick_size());
                n_rows = sb.frame_size(sb.rows_reg, glpf_pkg::MAX_ROWS);
                n_cols = sb.frame_size(sb.cols_reg, glpf_pkg::MAX_COLS);
                n = $urandom_range(1, 3) * n_rows * n_cols;
                if (n > FEED_CAP)
                    n = FEED_CAP;
                // broken frame, cut short by the next size write
                if ($urandom_range(4) == 0)
                    n = $urandom_range(1, n - 1);
                if (n > RANDOM_ITEMS - random_taken)
                    n = RANDOM_ITEMS - random_taken;
                feed(n);
                random_taken += n;
            end
            pause_for_idle();
        end

        pause_for_idle();
        repeat (20)
            @(posedge clk);
        if (sb.mismatches == 0 && sb.due_peaks.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
